@@ sv/sbct_pkg.sv @@
`default_nettype none
package sbct_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int HALF_BITS      = 31;
endpackage
`default_nettype wire

@@ sv/segment_box_crossing_test.sv @@
// Channel | Direction | Handshake         | Payload
// input   | in        | i_valid, o_stall  | segment end points, box center, halves, orientation
// output  | out       | o_valid, i_stall  | o_crosses
//
// Five register stages: input, box edges and y-order swap, differences and thresholds,
// products, compare. One request enters per cycle while the output is not stalled.
// The clipped x test is done by comparing the numerator against threshold times
// denominator, so no divider is needed; the product stage sets the depth.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes every stage; o_stall follows i_stall while a result waits.
`default_nettype none
module segment_box_crossing_test
    import sbct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [COORD_BITS-1:0] i_box_center_x,
    input  wire logic [COORD_BITS-1:0] i_box_center_y,
    input  wire logic [HALF_BITS-1:0]  i_short_half,
    input  wire logic [HALF_BITS-1:0]  i_long_half,
    input  wire logic                  i_long_along_x,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_crosses
);
    localparam int D = ((COORD_BITS > HALF_BITS + 1) ? COORD_BITS : HALF_BITS + 1) + 4;
    localparam int P = 2 * D;

    typedef logic signed [D-1:0] t_s;
    typedef logic signed [P-1:0] t_p;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_ov;

    assign en      = !(r_ov && i_stall);
    assign o_stall = r_ov && i_stall;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    // stage 1: sign extend
    t_s r_x1, r_y1, r_x2, r_y2, r_cx, r_cy, r_hx, r_hy;
    t_s n_hl, n_hs;
    assign n_hl = t_s'({{(D-HALF_BITS){1'b0}}, i_long_half});
    assign n_hs = t_s'({{(D-HALF_BITS){1'b0}}, i_short_half});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1 <= t_s'({{(D-COORD_BITS){i_start_x[COORD_BITS-1]}}, i_start_x});
            r_y1 <= t_s'({{(D-COORD_BITS){i_start_y[COORD_BITS-1]}}, i_start_y});
            r_x2 <= t_s'({{(D-COORD_BITS){i_end_x[COORD_BITS-1]}}, i_end_x});
            r_y2 <= t_s'({{(D-COORD_BITS){i_end_y[COORD_BITS-1]}}, i_end_y});
            r_cx <= t_s'({{(D-COORD_BITS){i_box_center_x[COORD_BITS-1]}}, i_box_center_x});
            r_cy <= t_s'({{(D-COORD_BITS){i_box_center_y[COORD_BITS-1]}}, i_box_center_y});
            r_hx <= i_long_along_x ? n_hl : n_hs;
            r_hy <= i_long_along_x ? n_hs : n_hl;
        end
    end

    // stage 2: edges, center offsets, order by y
    t_s r_lbx, r_rux, r_lby, r_ruy, r_ax, r_ay, r_bx, r_by;
    t_s r_sx1, r_sy1, r_sx2, r_sy2;
    logic n_swap;
    assign n_swap = r_y1 > r_y2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lbx <= r_cx - r_hx;
            r_rux <= r_cx + r_hx;
            r_lby <= r_cy - r_hy;
            r_ruy <= r_cy + r_hy;
            r_ax  <= r_x1 - r_cx;
            r_ay  <= r_y1 - r_cy;
            r_bx  <= r_x2 - r_cx;
            r_by  <= r_y2 - r_cy;
            r_sx1 <= n_swap ? r_x2 : r_x1;
            r_sy1 <= n_swap ? r_y2 : r_y1;
            r_sx2 <= n_swap ? r_x1 : r_x2;
            r_sy2 <= n_swap ? r_y1 : r_y2;
        end
    end

    // stage 3: differences, clip flags, thresholds
    t_s n_dx, n_dyc, n_dyd, n_tr, n_tl, n_cya, n_dya;
    logic n_clipc, n_clipd, n_nnc, n_nnd;
    t_s r_dx, r_den, r_dyc, r_dyd, r_tcr, r_tcl, r_tdr, r_tdl;
    t_s r_ax3, r_ay3, r_bx3, r_by3;
    logic r_horiz, r_hin, r_clipc, r_clipd, r_nnc, r_nnd, r_dge;
    logic r_gt1, r_lt1, r_gt2, r_lt2;

    assign n_dx    = r_sx2 - r_sx1;
    assign n_dyc   = r_lby - r_sy1;
    assign n_dyd   = r_ruy - r_sy1;
    assign n_tr    = r_rux - r_sx1;
    assign n_tl    = r_lbx - r_sx1 - t_s'(1);
    assign n_clipc = r_sy1 < r_lby;
    assign n_clipd = r_sy2 > r_ruy;
    assign n_cya   = n_clipc ? r_lby : r_sy1;
    assign n_dya   = n_clipd ? r_ruy : r_sy2;
    assign n_nnc   = (n_dx[D-1] == n_dyc[D-1]) || (n_dx == '0) || (n_dyc == '0);
    assign n_nnd   = (n_dx[D-1] == n_dyd[D-1]) || (n_dx == '0) || (n_dyd == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= n_dx;
            r_den   <= r_sy2 - r_sy1;
            r_dyc   <= n_dyc;
            r_dyd   <= n_dyd;
            r_tcr   <= n_tr + t_s'({{(D-1){1'b0}}, n_nnc});
            r_tcl   <= n_tl + t_s'({{(D-1){1'b0}}, n_nnc});
            r_tdr   <= n_tr + t_s'({{(D-1){1'b0}}, n_nnd});
            r_tdl   <= n_tl + t_s'({{(D-1){1'b0}}, n_nnd});
            r_ax3   <= r_ax;
            r_ay3   <= r_ay;
            r_bx3   <= r_bx;
            r_by3   <= r_by;
            r_horiz <= r_sy1 == r_sy2;
            r_hin   <= (r_sy1 <= r_ruy) && (r_sy1 >= r_lby);
            r_clipc <= n_clipc;
            r_clipd <= n_clipd;
            r_nnc   <= n_nnc;
            r_nnd   <= n_nnd;
            r_dge   <= n_dya >= n_cya;
            r_gt1   <= r_sx1 > r_rux;
            r_lt1   <= r_sx1 < r_lbx;
            r_gt2   <= r_sx2 > r_rux;
            r_lt2   <= r_sx2 < r_lbx;
        end
    end

    // stage 4: products
    t_p r_pa, r_pb, r_nc, r_nd, r_mcr, r_mcl, r_mdr, r_mdl;
    logic r4_horiz, r4_hin, r4_clipc, r4_clipd, r4_nnc, r4_nnd, r4_dge;
    logic r4_gt1, r4_lt1, r4_gt2, r4_lt2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa     <= P'(r_ax3) * P'(r_by3);
            r_pb     <= P'(r_ay3) * P'(r_bx3);
            r_nc     <= P'(r_dx) * P'(r_dyc);
            r_nd     <= P'(r_dx) * P'(r_dyd);
            r_mcr    <= P'(r_tcr) * P'(r_den);
            r_mcl    <= P'(r_tcl) * P'(r_den);
            r_mdr    <= P'(r_tdr) * P'(r_den);
            r_mdl    <= P'(r_tdl) * P'(r_den);
            r4_horiz <= r_horiz;
            r4_hin   <= r_hin;
            r4_clipc <= r_clipc;
            r4_clipd <= r_clipd;
            r4_nnc   <= r_nnc;
            r4_nnd   <= r_nnd;
            r4_dge   <= r_dge;
            r4_gt1   <= r_gt1;
            r4_lt1   <= r_lt1;
            r4_gt2   <= r_gt2;
            r4_lt2   <= r_lt2;
        end
    end

    // stage 5: compare
    logic n_gtc, n_ltc, n_gtd, n_ltd, n_cross, r_cross;

    assign n_gtc = r4_clipc ? (r4_nnc ? (r_nc >= r_mcr) : (r_nc > r_mcr)) : r4_gt1;
    assign n_ltc = r4_clipc ? !(r4_nnc ? (r_nc >= r_mcl) : (r_nc > r_mcl)) : r4_lt1;
    assign n_gtd = r4_clipd ? (r4_nnd ? (r_nd >= r_mdr) : (r_nd > r_mdr)) : r4_gt2;
    assign n_ltd = r4_clipd ? !(r4_nnd ? (r_nd >= r_mdl) : (r_nd > r_mdl)) : r4_lt2;

    always_comb begin
        if (r_pa == r_pb) begin
            n_cross = 1'b1;
        end else if (r4_horiz) begin
            n_cross = r4_hin && !(r4_gt1 && r4_gt2) && !(r4_lt1 && r4_lt2);
        end else begin
            n_cross = r4_dge && !(n_gtc && n_gtd) && !(n_ltc && n_ltd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cross <= n_cross;
        end
    end

    assign o_crosses = r_cross;
endmodule
`default_nettype wire

@@ sv/sbct_checker.sv @@
`default_nettype none
module sbct_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_crosses
);
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_crosses))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall && o_valid)
        else $error("input stalled without a blocked result");
endmodule

bind segment_box_crossing_test sbct_checker u_sbct_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_crosses (o_crosses)
);
`default_nettype wire

@@ tb/tb_segment_box_crossing_test.sv @@
`default_nettype none
module tb_segment_box_crossing_test;
    import sbct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [CB-1:0]        sx, sy, ex, ey, cx, cy;
        logic [HALF_BITS-1:0] sh, lh;
        logic                 ax;
    } t_seg_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CB-1:0]        i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic [CB-1:0]        i_box_center_x = '0, i_box_center_y = '0;
    logic [HALF_BITS-1:0] i_short_half = '0, i_long_half = '0;
    logic                 i_long_along_x = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_crosses;

    bit   crossing_q[$];
    int   errors = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_len = 0;
    int   cycles = 0;

    segment_box_crossing_test #(.COORD_BITS(CB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_wide clip_x(t_wide x1, t_wide x2, t_wide y1, t_wide yt, t_wide den);
        t_wide q;
        t_wide lim;
        lim = t_wide'(1) <<< 62;
        q = ((x2 - x1) * (yt - y1)) / den;
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return x1 + q;
    endfunction

    function automatic bit spans(t_wide lo, t_wide hi, t_wide p, t_wide r);
        t_wide a, b;
        a = (p < r) ? p : r;
        b = (p < r) ? r : p;
        return !(a > hi || b < lo);
    endfunction

    function automatic bit predict_crossing(t_seg_req r);
        t_wide x1, y1, x2, y2, cx, cy, hx, hy, lbx, rux, lby, ruy, t, den;
        t_wide cxa, cya, dxa, dya;
        x1 = $signed(r.sx); y1 = $signed(r.sy);
        x2 = $signed(r.ex); y2 = $signed(r.ey);
        cx = $signed(r.cx); cy = $signed(r.cy);
        hx = r.ax ? t_wide'(r.lh) : t_wide'(r.sh);
        hy = r.ax ? t_wide'(r.sh) : t_wide'(r.lh);
        lbx = cx - hx; rux = cx + hx; lby = cy - hy; ruy = cy + hy;
        if ((x1 - cx) * (y2 - cy) == (y1 - cy) * (x2 - cx)) return 1'b1;
        if (y1 > y2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        if (y1 == y2) return (y1 <= ruy && y1 >= lby) && spans(lbx, rux, x1, x2);
        den = y2 - y1;
        if (y1 < lby) begin
            cya = lby; cxa = clip_x(x1, x2, y1, lby, den);
        end else begin
            cya = y1; cxa = x1;
        end
        if (y2 > ruy) begin
            dya = ruy; dxa = clip_x(x1, x2, y1, ruy, den);
        end else begin
            dya = y2; dxa = x2;
        end
        return (dya >= cya) && spans(lbx, rux, dxa, cxa);
    endfunction

    function automatic logic [31:0] small_off(int bits);
        return $urandom_range((1 << bits) - 1) - (1 << (bits - 1));
    endfunction

    function automatic t_seg_req random_request();
        t_seg_req r;
        int mode;
        logic [31:0] dx, dy;
        int k1, k2;
        mode = $urandom_range(9);
        r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
        r.cx = $urandom; r.cy = $urandom;
        r.sh = HALF_BITS'($urandom); r.lh = HALF_BITS'($urandom);
        r.ax = 1'($urandom_range(1));
        if (mode >= 2) begin
            r.cx = $urandom_range(1) ? $urandom : small_off(24);
            r.cy = $urandom_range(1) ? $urandom : small_off(24);
            r.sh = HALF_BITS'($urandom_range(1 << 20));
            r.lh = HALF_BITS'(r.sh + $urandom_range(1 << 20));
            r.sx = r.cx + small_off(23); r.sy = r.cy + small_off(23);
            r.ex = r.cx + small_off(23); r.ey = r.cy + small_off(23);
        end
        if (mode == 7) begin
            dx = small_off(12); dy = small_off(12);
            k1 = $urandom_range(2000) - 1000; k2 = $urandom_range(2000) - 1000;
            r.sx = r.cx + dx * k1; r.sy = r.cy + dy * k1;
            r.ex = r.cx + dx * k2; r.ey = r.cy + dy * k2;
        end
        if (mode == 8) r.ey = r.sy;
        if (mode == 9) begin
            r.ey = r.sy + $urandom_range(3);
            r.ex = r.sx + ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
        end
        return r;
    endfunction

    task automatic send_request(t_seg_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_x <= r.sx; i_start_y <= r.sy; i_end_x <= r.ex; i_end_y <= r.ey;
        i_box_center_x <= r.cx; i_box_center_y <= r.cy;
        i_short_half <= r.sh; i_long_half <= r.lh; i_long_along_x <= r.ax;
        do @(posedge i_clk); while (o_stall);
        crossing_q = {crossing_q, predict_crossing(r)};
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (crossing_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic seg(logic [31:0] sx, sy, ex, ey, cx, cy,
                       logic [30:0] sh, lh, logic ax);
        t_seg_req r;
        r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.cx = cx; r.cy = cy;
        r.sh = sh; r.lh = lh; r.ax = ax;
        send_request(r);
    endtask

    task automatic test_directed();
        seg(0, 0, 0, 0, 0, 0, 0, 0, 0);
        seg(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0,
            31'h7fff_ffff, 31'h7fff_ffff, 1);
        seg(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 0, 31'h7fff_ffff, 0);
        seg(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0007_0000,
            32'h0001_0000, 32'h0002_0000, 5, 9, 0);
        // line through center, segment short of the box
        seg(32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'h0020_0000, 0, 0,
            31'h100, 31'h200, 1);
        // horizontal inside, above, touching top edge, beside
        seg(32'hfff0_0000, 32'h0000_8000, 32'h0010_0000, 32'h0000_8000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        seg(32'hfff0_0000, 32'h0003_0000, 32'h0010_0000, 32'h0003_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        seg(32'hfff0_0000, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        seg(32'h0005_0000, 32'h0000_8000, 32'h0009_0000, 32'h0000_8000, 0, 0,
            31'h1_0000, 31'h2_0000, 0);
        // vertical through, beside; diagonal clipped both ends
        seg(32'h0000_8000, 32'hfff0_0000, 32'h0000_8000, 32'h0010_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        seg(32'h0003_0000, 32'hfff0_0000, 32'h0003_0000, 32'h0010_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        seg(32'h0003_0000, 32'h0010_0000, 32'hfff8_0000, 32'hfff0_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 0);
        seg(32'h0030_0000, 32'h0010_0000, 32'h0020_0000, 32'hfff0_0000, 0, 0,
            31'h1_0000, 31'h2_0000, 1);
        // saturating clip: large dx over tiny dy
        seg(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001,
            32'h1234_0000, 32'h7000_0000, 31'h10, 31'h20, 0);
        seg(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
            32'h0000_0000, 32'h0010_0000, 31'h7fff_ffff, 31'h7fff_ffff, 0);
        seg(0, 1, 1, 0, 0, 0, 0, 0, 1);
        seg(32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'h2, 32'h5, 32'h5, 1, 1, 0);
        go_idle();
        wait_drain();
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_request(random_request());
        go_idle();
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len = 150;
        repeat (60) send_request(random_request());
        go_idle();
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossing_q.size() == 0) begin
                $display("%0t: unexpected result crosses=%0b", $realtime, o_crosses);
                errors++;
            end else begin
                if (o_crosses !== crossing_q[0]) begin
                    $display("%0t: crosses mismatch expected=%0b actual=%0b",
                             $realtime, crossing_q[0], o_crosses);
                    errors++;
                end
                void'(crossing_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(550, 16, 86);
        test_random(550, 86, 16);
        test_backpressure();
        test_random(500, 0, 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && crossing_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/sbct_pkg.sv
sv/segment_box_crossing_test.sv
sv/sbct_checker.sv
tb/tb_segment_box_crossing_test.sv
